@@ hw/rtl/ntclin_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ntclin_pkg;

  localparam int unsigned ROM_POINTS = 37;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned ADC_IN_W   = 12;
  localparam int unsigned SER_W      = 20;
  localparam int unsigned RES_W      = 30;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned XTAB_W     = 25;
  localparam int unsigned YTAB_W     = 12;

  // Shared shift-subtract divider
  localparam int unsigned DVD_W      = 48;
  localparam int unsigned DSR_W      = 26;
  localparam int unsigned CNT_W      = 6;
  localparam logic [CNT_W-1:0] DIV_RES_STEPS = CNT_W'(36);
  localparam logic [CNT_W-1:0] DIV_TMP_STEPS = CNT_W'(48);

  localparam logic [SER_W-1:0] SERIES_RESET = SER_W'(10000);
  localparam logic [RES_W-1:0] RES_MAX      = '1;

  typedef enum logic [1:0] {
    STAT_INTERP     = 2'd0,
    STAT_EXTRAP     = 2'd1,
    STAT_FULL_SCALE = 2'd2,
    STAT_SAT        = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_RES,
    ST_SAT,
    ST_SEARCH,
    ST_DIFF,
    ST_PROD,
    ST_PREP,
    ST_DIV_TMP,
    ST_ADJ,
    ST_SUM,
    ST_DONE
  } state_e;

  // Thermistor resistance points, ohms Q.4, strictly descending
  function automatic logic [XTAB_W-1:0] res_point(input logic [IDX_W-1:0] idx);
    logic [XTAB_W-1:0] v;
    unique case (idx)
      6'd0:  v = XTAB_W'(19433600);
      6'd1:  v = XTAB_W'(13510240);
      6'd2:  v = XTAB_W'(9478880);
      6'd3:  v = XTAB_W'(6710080);
      6'd4:  v = XTAB_W'(4791680);
      6'd5:  v = XTAB_W'(3450720);
      6'd6:  v = XTAB_W'(2502560);
      6'd7:  v = XTAB_W'(1834560);
      6'd8:  v = XTAB_W'(1352160);
      6'd9:  v = XTAB_W'(1006832);
      6'd10: v = XTAB_W'(753232);
      6'd11: v = XTAB_W'(569008);
      6'd12: v = XTAB_W'(433904);
      6'd13: v = XTAB_W'(333760);
      6'd14: v = XTAB_W'(259264);
      6'd15: v = XTAB_W'(202928);
      6'd16: v = XTAB_W'(160000);
      6'd17: v = XTAB_W'(127072);
      6'd18: v = XTAB_W'(101232);
      6'd19: v = XTAB_W'(81184);
      6'd20: v = XTAB_W'(65648);
      6'd21: v = XTAB_W'(53376);
      6'd22: v = XTAB_W'(43584);
      6'd23: v = XTAB_W'(35792);
      6'd24: v = XTAB_W'(29536);
      6'd25: v = XTAB_W'(24480);
      6'd26: v = XTAB_W'(20400);
      6'd27: v = XTAB_W'(17088);
      6'd28: v = XTAB_W'(14389);
      6'd29: v = XTAB_W'(12171);
      6'd30: v = XTAB_W'(10323);
      6'd31: v = XTAB_W'(8790);
      6'd32: v = XTAB_W'(7520);
      6'd33: v = XTAB_W'(6458);
      6'd34: v = XTAB_W'(5558);
      6'd35: v = XTAB_W'(4802);
      6'd36: v = XTAB_W'(4162);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Temperature points, degrees C Q.4, -55 to 125 in 5 degree steps
  function automatic logic signed [YTAB_W-1:0] temp_point(input logic [IDX_W-1:0] idx);
    logic signed [YTAB_W-1:0] v;
    unique case (idx)
      6'd0:  v = -12'sd880;
      6'd1:  v = -12'sd800;
      6'd2:  v = -12'sd720;
      6'd3:  v = -12'sd640;
      6'd4:  v = -12'sd560;
      6'd5:  v = -12'sd480;
      6'd6:  v = -12'sd400;
      6'd7:  v = -12'sd320;
      6'd8:  v = -12'sd240;
      6'd9:  v = -12'sd160;
      6'd10: v = -12'sd80;
      6'd11: v = 12'sd0;
      6'd12: v = 12'sd80;
      6'd13: v = 12'sd160;
      6'd14: v = 12'sd240;
      6'd15: v = 12'sd320;
      6'd16: v = 12'sd400;
      6'd17: v = 12'sd480;
      6'd18: v = 12'sd560;
      6'd19: v = 12'sd640;
      6'd20: v = 12'sd720;
      6'd21: v = 12'sd800;
      6'd22: v = 12'sd880;
      6'd23: v = 12'sd960;
      6'd24: v = 12'sd1040;
      6'd25: v = 12'sd1120;
      6'd26: v = 12'sd1200;
      6'd27: v = 12'sd1280;
      6'd28: v = 12'sd1360;
      6'd29: v = 12'sd1440;
      6'd30: v = 12'sd1520;
      6'd31: v = 12'sd1600;
      6'd32: v = 12'sd1680;
      6'd33: v = 12'sd1760;
      6'd34: v = 12'sd1840;
      6'd35: v = 12'sd1920;
      6'd36: v = 12'sd2000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ntclin_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ntclin_in_if import ntclin_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_IN_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntclin_out_if import ntclin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic        [RES_W-1:0]  resistance;
  logic        [1:0]        status;

  modport source (output valid, output temperature, output resistance, output status,
                  input ready);
  modport sink   (input valid, input temperature, input resistance, input status,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ntc_thermistor_linearizer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Each request runs through the shared shift-subtract divider (36 steps for resistance, 48
//   for temperature) and the segment scan, which tests one table point per cycle; a
//   full-scale code goes straight to the result.
// Requests: taken one at a time, a full-scale code included; the next is
//   taken once the sequencer is idle again, while a finished result may still wait in the
//   output register. A result that is not taken holds the sequencer in its last state.
// Reset: asynchronous, active low; series resistance returns to 10000 ohms, no result pending.
module ntc_thermistor_linearizer import ntclin_pkg::*; #(
  parameter int unsigned TABLE_POINTS = 37,
  parameter int unsigned ADC_BITS     = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [SER_W-1:0] cfg_wdata_i,
  ntclin_in_if.sink             req_i,
  ntclin_out_if.source          rsp_o
);

  localparam int unsigned USED_POINTS = (TABLE_POINTS < ROM_POINTS) ? TABLE_POINTS : ROM_POINTS;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(USED_POINTS - 1);
  localparam int unsigned CODE_W = (ADC_BITS < ADC_IN_W) ? ADC_BITS : ADC_IN_W;
  localparam logic [ADC_BITS-1:0] AdcFull = '1;

  state_e state_q, state_d;

  logic [SER_W-1:0]         series_q;
  logic [ADC_IN_W-1:0]      code_q;
  logic                     fs_q;
  logic [RES_W-1:0]         r_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     beyond_q;
  logic [XTAB_W-1:0]        dx_q;
  logic signed [12:0]       dy_q;
  logic signed [31:0]       off_q;
  logic signed [YTAB_W-1:0] ysel_q;
  logic signed [44:0]       num_q;
  logic                     neg_q;
  logic [49:0]              sq_q;
  logic [50:0]              sum_q;

  logic [DVD_W-1:0]         dvd_q;
  logic [DSR_W-1:0]         dsr_q;
  logic [DSR_W-1:0]         rem_q;
  logic [CNT_W-1:0]         cnt_q;

  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic [RES_W-1:0]         out_res_q;
  logic [1:0]               out_stat_q;

  // Input decode
  logic [CODE_W-1:0]   code_eff;
  logic [ADC_BITS-1:0] code_ext;
  logic                full_scale;
  logic [ADC_BITS-1:0] den;

  assign code_eff   = req_i.adc_code[CODE_W-1:0];
  assign code_ext   = ADC_BITS'(code_eff);
  assign full_scale = (code_ext == AdcFull);
  assign den        = AdcFull - code_ext;

  logic accept;
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Shared divider step
  logic [DSR_W:0]   partial;
  logic             div_ge;
  logic [DSR_W-1:0] rem_next;
  logic             div_active;
  logic             div_last;

  assign partial    = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge     = (partial >= {1'b0, dsr_q});
  assign rem_next   = div_ge ? DSR_W'(partial - {1'b0, dsr_q}) : partial[DSR_W-1:0];
  assign div_active = (state_q == ST_DIV_RES) || (state_q == ST_DIV_TMP);
  assign div_last   = (cnt_q == CNT_W'(1));

  // Segment scan
  logic [XTAB_W-1:0] x_cur;
  logic              seg_hit;
  assign x_cur   = res_point(idx_q);
  assign seg_hit = (r_q > RES_W'(x_cur)) || (idx_q == LastIdx);

  // Interpolation terms
  logic [IDX_W-1:0] idx_prev;
  logic [46:0]      n2;
  logic [46:0]      n2_mag;
  logic [49:0]      q_adj;
  assign idx_prev = idx_q - IDX_W'(1);
  assign n2       = {num_q[44], num_q, 1'b0} + 47'(dx_q);
  assign n2_mag   = n2[46] ? (~n2 + 47'd1) : n2;
  assign q_adj    = 50'(dvd_q) + 50'((neg_q && (rem_q != '0)) ? 1 : 0);

  // Final clamp and status
  logic                     over, under;
  logic signed [TEMP_W-1:0] temp_fin;
  status_e                  stat_fin;
  logic                     out_load;

  assign over  = !sum_q[50] && (|sum_q[49:15]);
  assign under = sum_q[50] && !(&sum_q[49:15]);

  always_comb begin
    temp_fin = sum_q[TEMP_W-1:0];
    stat_fin = beyond_q ? STAT_EXTRAP : STAT_INTERP;
    priority if (fs_q) begin
      temp_fin = '0;
      stat_fin = STAT_FULL_SCALE;
    end else if (over) begin
      temp_fin = 16'sh7fff;
      stat_fin = STAT_SAT;
    end else if (under) begin
      temp_fin = -16'sh8000;
      stat_fin = STAT_SAT;
    end else begin
      temp_fin = sum_q[TEMP_W-1:0];
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = full_scale ? ST_DONE : ST_MUL;
      ST_MUL:     state_d = ST_DIV_RES;
      ST_DIV_RES: if (div_last) state_d = ST_SAT;
      ST_SAT:     state_d = ST_SEARCH;
      ST_SEARCH:  if (seg_hit) state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_PROD;
      ST_PROD:    state_d = ST_PREP;
      ST_PREP:    state_d = ST_DIV_TMP;
      ST_DIV_TMP: if (div_last) state_d = ST_ADJ;
      ST_ADJ:     state_d = ST_SUM;
      ST_SUM:     state_d = ST_DONE;
      ST_DONE:    if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= SERIES_RESET;
    end else if (cfg_we_i) begin
      series_q <= cfg_wdata_i;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          code_q <= ADC_IN_W'(code_eff);
          fs_q   <= full_scale;
          r_q    <= RES_MAX;
          dsr_q  <= DSR_W'(den);
        end
      end
      ST_MUL: begin
        dvd_q <= {32'(series_q) * 32'(code_q), 4'b0, 12'b0};
        rem_q <= '0;
        cnt_q <= DIV_RES_STEPS;
      end
      ST_DIV_RES, ST_DIV_TMP: begin
        dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
        rem_q <= rem_next;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_SAT: begin
        r_q   <= (|dvd_q[DVD_W-1:RES_W]) ? RES_MAX : dvd_q[RES_W-1:0];
        idx_q <= IDX_W'(1);
      end
      ST_SEARCH: begin
        // Hold idx_q on the hit; it names the segment end
        if (seg_hit) begin
          beyond_q <= (r_q > RES_W'(res_point('0))) || (r_q < RES_W'(res_point(LastIdx)));
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      ST_DIFF: begin
        dx_q   <= res_point(idx_prev) - x_cur;
        dy_q   <= 13'(temp_point(idx_prev)) - 13'(temp_point(idx_q));
        off_q  <= signed'({2'b0, r_q}) - signed'(32'(x_cur));
        ysel_q <= temp_point(idx_q);
      end
      ST_PROD: begin
        num_q <= 45'(dy_q) * 45'(off_q);
      end
      ST_PREP: begin
        neg_q <= n2[46];
        dvd_q <= DVD_W'(n2_mag);
        dsr_q <= DSR_W'({dx_q, 1'b0});
        rem_q <= '0;
        cnt_q <= DIV_TMP_STEPS;
      end
      ST_ADJ: begin
        // Floor division of a negative numerator: round the magnitude up, then negate
        sq_q <= neg_q ? (~q_adj + 50'd1) : q_adj;
      end
      ST_SUM: begin
        sum_q <= {sq_q[49], sq_q} + 51'(ysel_q);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_temp_q <= temp_fin;
      out_res_q  <= r_q;
      out_stat_q <= stat_fin;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.temperature = out_temp_q;
  assign rsp_o.resistance  = out_res_q;
  assign rsp_o.status      = out_stat_q;

endmodule

`default_nettype wire
